>>> sv/bpfw_pkg.sv
// ----------------------------------------------------------------------------
// bpfw_pkg
// Shared types, constants and helpers for the BMP pixel to framebuffer writer.
// ----------------------------------------------------------------------------
package bpfw_pkg;

    localparam int SCREEN_WIDTH   = 1024;
    localparam int SCREEN_HEIGHT  = 600;
    localparam int MAX_IMAGE_SIDE = 4096;

    localparam int ADDR_W  = 20;
    localparam int COLOR_W = 32;
    localparam int CNT_W   = 12;
    localparam int SIDE_W  = 13;
    localparam int POS_W   = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_PIXEL_FORMAT = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        FMT_BGR24  = 1'b0,
        FMT_BGRA32 = 1'b1
    } pixel_fmt_t;

    typedef struct packed {
        logic signed [12:0] origin_x;
        logic signed [12:0] origin_y;
        logic signed [13:0] image_width;
        logic signed [13:0] image_height;
        pixel_fmt_t         pixel_format;
    } cfg_t;

    // one finished pixel from the byte tracker
    typedef struct packed {
        logic               hit;
        logic [CNT_W-1:0]   column;
        logic [CNT_W-1:0]   row;
        logic [COLOR_W-1:0] color;
    } pix_t;

    // placed pixel, ready for the result register
    typedef struct packed {
        logic               write;
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] color;
    } place_t;

    // absolute value of a signed side, saturated to the largest image side
    function automatic logic [SIDE_W-1:0] side_magnitude(input logic signed [13:0] v);
        logic [14:0] ext;
        logic [14:0] mag;
        ext = {v[13], v};
        mag = v[13] ? (~ext + 15'd1) : ext;
        if (mag > 15'(MAX_IMAGE_SIDE))
        begin
            mag = 15'(MAX_IMAGE_SIDE);
        end
        return mag[SIDE_W-1:0];
    endfunction

endpackage

>>> sv/bpfw_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpfw_cfg_regs
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
module bpfw_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bpfw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpfw_pkg::CFG_DATA_W-1:0] cfg_data,
    output bpfw_pkg::cfg_t                 cfg
);

    bpfw_pkg::cfg_t cfg_reg;
    bpfw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (bpfw_pkg::cfg_reg_t'(cfg_index))
                bpfw_pkg::REG_ORIGIN_X:     cfg_next.origin_x     = signed'(cfg_data[12:0]);
                bpfw_pkg::REG_ORIGIN_Y:     cfg_next.origin_y     = signed'(cfg_data[12:0]);
                bpfw_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width  = signed'(cfg_data);
                bpfw_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height = signed'(cfg_data);
                bpfw_pkg::REG_PIXEL_FORMAT:
                    cfg_next.pixel_format = bpfw_pkg::pixel_fmt_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.image_width  <= 14'sd1024;
            cfg_reg.image_height <= 14'sd600;
            cfg_reg.pixel_format <= bpfw_pkg::FMT_BGR24;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/bpfw_pixel_tracker.sv
// ----------------------------------------------------------------------------
// bpfw_pixel_tracker
// Byte phase, color assembly, column/row counters and row padding skip.
// ----------------------------------------------------------------------------
module bpfw_pixel_tracker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           pixel_byte,
    input  logic                 image_start,
    input  bpfw_pkg::cfg_t       cfg,
    output bpfw_pkg::pix_t       pix
);

    logic [1:0]                  phase_reg, phase_next;
    logic [23:0]                 partial_reg, partial_next;
    logic [bpfw_pkg::CNT_W-1:0]  col_reg, col_next;
    logic [bpfw_pkg::CNT_W-1:0]  row_reg, row_next;
    logic [1:0]                  pad_reg, pad_next;
    logic                        done_reg, done_next;

    logic [1:0]                  phase_c;
    logic [23:0]                 partial_c;
    logic [bpfw_pkg::CNT_W-1:0]  col_c;
    logic [bpfw_pkg::CNT_W-1:0]  row_c;
    logic [1:0]                  pad_c;
    logic                        done_c;
    logic [23:0]                 merged;
    logic                        complete;
    logic [bpfw_pkg::SIDE_W-1:0] absw;
    logic [bpfw_pkg::SIDE_W-1:0] absh;

    assign absw = bpfw_pkg::side_magnitude(cfg.image_width);
    assign absh = bpfw_pkg::side_magnitude(cfg.image_height);

    always_comb
    begin
        // a new image clears everything before its first byte is used
        phase_c   = image_start ? 2'd0 : phase_reg;
        partial_c = image_start ? 24'd0 : partial_reg;
        col_c     = image_start ? '0 : col_reg;
        row_c     = image_start ? '0 : row_reg;
        pad_c     = image_start ? 2'd0 : pad_reg;
        done_c    = image_start ? 1'b0 : done_reg;

        phase_next   = phase_c;
        partial_next = partial_c;
        col_next     = col_c;
        row_next     = row_c;
        pad_next     = pad_c;
        done_next    = done_c;

        case (phase_c)
            2'd0:    merged = partial_c | {16'd0, pixel_byte};
            2'd1:    merged = partial_c | {8'd0, pixel_byte, 8'd0};
            2'd2:    merged = partial_c | {pixel_byte, 16'd0};
            default: merged = partial_c;
        endcase

        complete = (phase_c == 2'd3) ||
                   (phase_c == 2'd2 && cfg.pixel_format == bpfw_pkg::FMT_BGR24);

        pix.hit    = 1'b0;
        pix.column = col_c;
        pix.row    = row_c;
        pix.color  = {((phase_c == 2'd3) ? pixel_byte : 8'd0), merged};

        if (!done_c && absw != '0 && absh != '0)
        begin
            if (pad_c != 2'd0)
            begin
                pad_next = pad_c - 2'd1;
            end
            else if (!complete)
            begin
                phase_next   = phase_c + 2'd1;
                partial_next = merged;
            end
            else
            begin
                pix.hit      = 1'b1;
                phase_next   = 2'd0;
                partial_next = 24'd0;
                if ({1'b0, col_c} + 13'd1 >= absw)
                begin
                    col_next = '0;
                    if ({1'b0, row_c} + 13'd1 >= absh)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_c + 1'b1;
                        // 3*w bytes per row pads to w mod 4; 4-byte pixels need none
                        pad_next = (cfg.pixel_format == bpfw_pkg::FMT_BGR24) ?
                                   absw[1:0] : 2'd0;
                    end
                end
                else
                begin
                    col_next = col_c + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 2'd0;
            partial_reg <= 24'd0;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_reg     <= 2'd0;
            done_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
            done_reg    <= done_next;
        end
    end

    // padding is only armed at a pixel boundary
    a_pad_at_pixel_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg != 2'd0 |-> phase_reg == 2'd0 && partial_reg == 24'd0)
        else $error("row padding pending in the middle of a pixel");

    // the finished image leaves the column counter at zero
    a_done_column_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> col_reg == '0 && pad_reg == 2'd0)
        else $error("image finished with column or padding state left over");

endmodule

>>> sv/bpfw_placer.sv
// ----------------------------------------------------------------------------
// bpfw_placer
// Screen position with flip and mirror, clipping and word address.
// ----------------------------------------------------------------------------
module bpfw_placer
(
    input  bpfw_pkg::pix_t   pix,
    input  bpfw_pkg::cfg_t   cfg,
    output bpfw_pkg::place_t place
);

    logic [bpfw_pkg::SIDE_W-1:0]       absw;
    logic [bpfw_pkg::SIDE_W-1:0]       absh;
    logic signed [bpfw_pkg::POS_W-1:0] col_s;
    logic signed [bpfw_pkg::POS_W-1:0] row_s;
    logic signed [bpfw_pkg::POS_W-1:0] x_off;
    logic signed [bpfw_pkg::POS_W-1:0] y_off;
    logic signed [bpfw_pkg::POS_W-1:0] x_pos;
    logic signed [bpfw_pkg::POS_W-1:0] y_pos;
    logic                              inside_screen;

    assign absw  = bpfw_pkg::side_magnitude(cfg.image_width);
    assign absh  = bpfw_pkg::side_magnitude(cfg.image_height);
    assign col_s = signed'({3'd0, pix.column});
    assign row_s = signed'({3'd0, pix.row});

    always_comb
    begin
        // negative width mirrors columns, positive height stores rows bottom-up
        if (cfg.image_width > 14'sd0)
        begin
            x_off = col_s;
        end
        else
        begin
            x_off = signed'({2'd0, absw}) - col_s - 15'sd1;
        end

        if (cfg.image_height > 14'sd0)
        begin
            y_off = signed'({2'd0, absh}) - row_s - 15'sd1;
        end
        else
        begin
            y_off = row_s;
        end

        x_pos = x_off + bpfw_pkg::POS_W'(cfg.origin_x);
        y_pos = y_off + bpfw_pkg::POS_W'(cfg.origin_y);

        inside_screen = (x_pos >= 15'sd0) &&
                        (x_pos < bpfw_pkg::POS_W'(bpfw_pkg::SCREEN_WIDTH)) &&
                        (y_pos >= 15'sd0) &&
                        (y_pos < bpfw_pkg::POS_W'(bpfw_pkg::SCREEN_HEIGHT));

        place.write   = pix.hit && inside_screen;
        place.address = bpfw_pkg::ADDR_W'(unsigned'(y_pos)) *
                        bpfw_pkg::ADDR_W'(bpfw_pkg::SCREEN_WIDTH) +
                        bpfw_pkg::ADDR_W'(unsigned'(x_pos));
        place.color   = pix.color;
    end

endmodule

>>> sv/bmp_pixel_to_framebuffer_writer.sv
// ----------------------------------------------------------------------------
// bmp_pixel_to_framebuffer_writer
// Streams BMP pixel-array bytes into ARGB8888 framebuffer word writes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one pixel-array byte per transfer,
// with image_start set on the first byte of each image. Output channel
// (out_valid/out_ready) carries one framebuffer write: fb_address is the word
// index row * 1024 + column, color is packed A,R,G,B from high to low byte.
// Bytes that only build up a pixel, pad bytes, clipped pixels and bytes after
// the last row produce no output transfer.
// Configuration is written through cfg_we/cfg_index/cfg_data between images.
// A byte is taken into the input register at its transfer, processed by the
// pixel logic and placer, and its write is captured in the output register.
// Throughput is one byte per cycle while not stalled; the input register,
// the pixel logic and the output register advance together whenever the
// output register is empty or being drained.
// When out_ready is low with a write pending, the pipeline holds and in_ready
// drops once the input register is full as well.
// Reset clears all counters, empties both registers and loads the register
// defaults (origin 0,0, 1024 x 600 bottom-up, 24-bit pixels).
// ----------------------------------------------------------------------------
module bmp_pixel_to_framebuffer_writer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      pixel_byte,
    input  logic                            image_start,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bpfw_pkg::ADDR_W-1:0]     fb_address,
    output logic [bpfw_pkg::COLOR_W-1:0]    color,
    input  logic                            cfg_we,
    input  logic [bpfw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpfw_pkg::CFG_DATA_W-1:0] cfg_data
);

    bpfw_pkg::cfg_t   cfg;
    bpfw_pkg::pix_t   pix;
    bpfw_pkg::place_t place;

    logic                         in_valid_reg;
    logic [7:0]                   byte_reg;
    logic                         start_reg;
    logic                         out_valid_reg;
    logic [bpfw_pkg::ADDR_W-1:0]  addr_reg;
    logic [bpfw_pkg::COLOR_W-1:0] color_reg;
    logic                         advance;
    logic                         step;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    bpfw_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpfw_pixel_tracker u_tracker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .pixel_byte  (byte_reg),
        .image_start (start_reg),
        .cfg         (cfg),
        .pix         (pix)
    );

    bpfw_placer u_placer
    (
        .pix   (pix),
        .cfg   (cfg),
        .place (place)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= pixel_byte;
            start_reg <= image_start;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && place.write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && place.write)
        begin
            addr_reg  <= place.address;
            color_reg <= place.color;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fb_address = addr_reg;
    assign color      = color_reg;

    a_addr_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            addr_reg < bpfw_pkg::ADDR_W'(bpfw_pkg::SCREEN_WIDTH * bpfw_pkg::SCREEN_HEIGHT))
        else $error("framebuffer address beyond the screen");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(byte_reg))
        else $error("stalled input byte lost");

    a_write_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        step && place.write |=> out_valid_reg)
        else $error("placed pixel did not reach the result register");

endmodule
